// ----- design/gbh_pkg.sv -----
// ----------------------------------------------------------------------------
// gbh_pkg
// Shared types, sizes and button masks of the gamepad hold tracker.
// ----------------------------------------------------------------------------
package gbh_pkg;

  localparam int PADS      = 4;
  localparam int BUTTONS   = 14;
  localparam int HOLD_BITS = 16;

  localparam int PAD_W   = (PADS > 1) ? $clog2(PADS) : 1;
  localparam int BTN_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int COUNT_W = $clog2(PADS + 1);

  localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               op;
    logic [1:0]         pad;
    logic               linked;
    logic [15:0]        button_word;
    logic [7:0]         left_trig_in;
    logic [7:0]         right_trig_in;
    logic signed [15:0] left_x_in;
    logic signed [15:0] left_y_in;
    logic signed [15:0] right_x_in;
    logic signed [15:0] right_y_in;
    logic [3:0]         button_sel;
  } item_t;

  typedef struct packed {
    logic               held;
    logic               just_pressed;
    logic               just_released;
    logic [15:0]        hold_count;
    logic [15:0]        release_hold;
    logic signed [15:0] left_x_out;
    logic signed [15:0] left_y_out;
    logic signed [15:0] right_x_out;
    logic signed [15:0] right_y_out;
    logic [7:0]         left_trig_out;
    logic [7:0]         right_trig_out;
    logic [2:0]         linked_count;
  } result_t;

  typedef struct packed {
    logic [BUTTONS-1:0]                cur;
    logic [BUTTONS-1:0]                prev;
    logic [BUTTONS-1:0][HOLD_BITS-1:0] hold;
    logic [BUTTONS-1:0][HOLD_BITS-1:0] rel;
    logic [7:0]                        trig_l;
    logic [7:0]                        trig_r;
    logic [15:0]                       lx;
    logic [15:0]                       ly;
    logic [15:0]                       rx;
    logic [15:0]                       ry;
  } pad_row_t;

  function automatic logic [15:0] button_mask(input logic [3:0] b);
    logic [15:0] m;
    case (b)
      4'd0:    m = 16'h1000;
      4'd1:    m = 16'h2000;
      4'd2:    m = 16'h4000;
      4'd3:    m = 16'h8000;
      4'd4:    m = 16'h0100;
      4'd5:    m = 16'h0200;
      4'd6:    m = 16'h0040;
      4'd7:    m = 16'h0080;
      4'd8:    m = 16'h0020;
      4'd9:    m = 16'h0010;
      4'd10:   m = 16'h0001;
      4'd11:   m = 16'h0002;
      4'd12:   m = 16'h0004;
      4'd13:   m = 16'h0008;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] low_word(input logic [HOLD_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

endpackage

// ----- design/gbh_pad_ram.sv -----
// ----------------------------------------------------------------------------
// gbh_pad_ram
// Per-pad state memory, one row per pad, registered read, row valid bits.
// ----------------------------------------------------------------------------
module gbh_pad_ram (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [gbh_pkg::PAD_W-1:0] rd_addr,
  output gbh_pkg::pad_row_t   rd_data,
  input  logic                wr_en,
  input  logic [gbh_pkg::PAD_W-1:0] wr_addr,
  input  gbh_pkg::pad_row_t   wr_data
);
  import gbh_pkg::*;

  pad_row_t        mem [PADS];
  logic [PADS-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // rows never written read as reset state
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ----- design/gbh_row_update.sv -----
// ----------------------------------------------------------------------------
// gbh_row_update
// Applies a poll to a pad row (a query leaves the row as it is) and forms the answer for the queried button.
// ----------------------------------------------------------------------------
module gbh_row_update (
  input  gbh_pkg::item_t    req,
  input  gbh_pkg::pad_row_t row_old,
  input  logic [2:0]        linked_count,
  output gbh_pkg::pad_row_t row_new,
  output gbh_pkg::result_t  res
);
  import gbh_pkg::*;

  logic [BTN_W-1:0] btn_idx;

  always_comb begin
    if (int'(req.button_sel) > BUTTONS - 1) begin
      btn_idx = BTN_W'(BUTTONS - 1);
    end else begin
      btn_idx = BTN_W'(req.button_sel);
    end
  end

  always_comb begin
    row_new = row_old;
    if (req.op == OP_POLL) begin
      row_new.prev = row_old.cur;
      for (int b = 0; b < BUTTONS; b++) begin
        if (req.linked) begin
          if (row_old.cur[b]) begin
            if (row_old.hold[b] != HOLD_MAX) begin
              row_new.hold[b] = row_old.hold[b] + HOLD_BITS'(1);
            end
          end else begin
            if (row_old.prev[b]) begin
              row_new.rel[b] = row_old.hold[b];
            end
            row_new.hold[b] = '0;
          end
          row_new.cur[b] = (req.button_word & button_mask(4'(b))) != 16'h0000;
        end else begin
          if (row_old.cur[b]) begin
            row_new.rel[b] = row_old.hold[b];
          end
          row_new.hold[b] = '0;
          row_new.cur[b]  = 1'b0;
        end
      end
      if (req.linked) begin
        row_new.trig_l = req.left_trig_in;
        row_new.trig_r = req.right_trig_in;
        row_new.lx     = req.left_x_in;
        row_new.ly     = req.left_y_in;
        row_new.rx     = req.right_x_in;
        row_new.ry     = req.right_y_in;
      end else begin
        row_new.trig_l = '0;
        row_new.trig_r = '0;
        row_new.lx     = '0;
        row_new.ly     = '0;
        row_new.rx     = '0;
        row_new.ry     = '0;
      end
    end
  end

  always_comb begin
    res.held           = row_new.cur[btn_idx];
    res.just_pressed   = row_new.cur[btn_idx] && !row_new.prev[btn_idx];
    res.just_released  = row_new.prev[btn_idx] && !row_new.cur[btn_idx];
    res.hold_count     = low_word(row_new.hold[btn_idx]);
    res.release_hold   = low_word(row_new.rel[btn_idx]);
    res.left_x_out     = row_new.lx;
    res.left_y_out     = row_new.ly;
    res.right_x_out    = row_new.rx;
    res.right_y_out    = row_new.ry;
    res.left_trig_out  = row_new.trig_l;
    res.right_trig_out = row_new.trig_r;
    res.linked_count   = linked_count;
  end

endmodule

// ----- design/gamepad_button_hold_tracker.sv -----
// ----------------------------------------------------------------------------
// gamepad_button_hold_tracker
// Button edge and hold tracking for up to four pads, one answer per word.
// ----------------------------------------------------------------------------
// For each word the pad's row is first read from the state memory, then it is
// updated, written back if the word is a poll, and the answer is loaded into the
// result register; the next word is taken only after that, so a new word is not
// accepted while the previous one is in flight. A waiting result holds the word
// in flight, with item_ready low, until the result register is free. State rows
// read as zero after reset through per-row valid bits, with no clearing pass.
module gamepad_button_hold_tracker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  gbh_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output gbh_pkg::result_t result
);
  import gbh_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic             state;
  item_t            req;
  logic [PAD_W-1:0] pad_idx;
  logic [PAD_W-1:0] pad_sel;
  logic [PADS-1:0]  pad_linked;
  logic [PADS-1:0]  pad_linked_next;
  logic [COUNT_W-1:0] linked_total;

  pad_row_t row_old;
  pad_row_t row_new;
  result_t  res;

  logic take;
  logic finish;
  logic ram_wr;

  assign item_ready = (state == ST_IDLE);
  assign take       = item_valid && item_ready;
  assign finish     = (state == ST_RD) && (!result_valid || result_ready);
  assign ram_wr     = finish && (req.op == OP_POLL);

  always_comb begin
    if (int'(item.pad) > PADS - 1) begin
      pad_sel = PAD_W'(PADS - 1);
    end else begin
      pad_sel = PAD_W'(item.pad);
    end
  end

  always_comb begin
    pad_linked_next = pad_linked;
    if (req.op == OP_POLL) begin
      pad_linked_next[pad_idx] = req.linked;
    end
    linked_total = COUNT_W'($countones(pad_linked_next));
  end

  gbh_pad_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (take),
    .rd_addr (pad_sel),
    .rd_data (row_old),
    .wr_en   (ram_wr),
    .wr_addr (pad_idx),
    .wr_data (row_new)
  );

  gbh_row_update u_update (
    .req          (req),
    .row_old      (row_old),
    .linked_count (3'(linked_total)),
    .row_new      (row_new),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pad_linked   <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (finish) begin
        pad_linked   <= pad_linked_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req     <= item;
      pad_idx <= pad_sel;
    end
    if (finish) begin
      result <= res;
    end
  end

  // checks
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> !item_ready)
    else $error("word taken while previous row still in flight");

  a_write_only_on_poll: assert property (@(posedge clk) disable iff (rst)
    ram_wr |-> (state == ST_RD) && (req.op == OP_POLL))
    else $error("state row written outside a poll");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    linked_total <= COUNT_W'(PADS))
    else $error("linked pad count out of range");

  a_edges_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.just_pressed && result.just_released))
    else $error("press and release flagged together");

  a_result_follows_finish: assert property (@(posedge clk) disable iff (rst)
    finish |=> result_valid)
    else $error("finished word produced no result");

endmodule

// ----- dv/tb_gamepad_button_hold_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_gamepad_button_hold_tracker
// Self-checking bench for the gamepad button hold tracker. A directed table
// covers reset state, index clamping, edges, release capture and disconnects.
// A short held-button run counts up the hold counter before a release. Random
// traffic with bursty input and a stalling receiver follows. Every answer is
// checked field by field against a typed answer or a bench-side model of pad state.
// ----------------------------------------------------------------------------
module tb_gamepad_button_hold_tracker;
  import gbh_pkg::*;

  localparam int CYCLE_LIMIT = 2500000;
  localparam int N_RANDOM    = 880;
  localparam int N_HOLD      = 12;

  // button index 13 down to 0
  localparam logic [13:0][15:0] BTN_MASK = {
    16'h0008, 16'h0004, 16'h0002, 16'h0001, 16'h0010, 16'h0020, 16'h0080,
    16'h0040, 16'h0200, 16'h0100, 16'h8000, 16'h4000, 16'h2000, 16'h1000
  };

  typedef struct {
    item_t   w;
    bit      typed;
    result_t ans;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item_word = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result_word;

  logic    pin_typed = 1'b0;
  result_t pin_answer = '0;

  // bench copy of the pad state
  logic [BUTTONS-1:0]   cur_q   [PADS];
  logic [BUTTONS-1:0]   prev_q  [PADS];
  logic [15:0]          hold_q  [PADS][BUTTONS];
  logic [15:0]          rel_q   [PADS][BUTTONS];
  logic                 link_q  [PADS];
  logic [7:0]           ltrig_q [PADS];
  logic [7:0]           rtrig_q [PADS];
  logic [15:0]          lx_q    [PADS];
  logic [15:0]          ly_q    [PADS];
  logic [15:0]          rx_q    [PADS];
  logic [15:0]          ry_q    [PADS];

  result_t expected_answers[$];
  int      err_count  = 0;
  int      n_checked  = 0;
  int      n_sent     = 0;
  int      cycle_count = 0;
  int      burst_left = 1;

  gamepad_button_hold_tracker i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t track_pad_word(item_t w);
    int          p;
    int          b;
    int          n;
    logic [13:0] oc;
    logic [13:0] ob;
    logic [13:0] nc;
    result_t     r;
    p = w.pad;
    b = (w.button_sel > 4'd13) ? 13 : w.button_sel;
    if (w.op == OP_POLL) begin
      oc = cur_q[p];
      ob = prev_q[p];
      nc = '0;
      for (int i = 0; i < BUTTONS; i++) begin
        if (w.linked) begin
          if (oc[i]) begin
            if (hold_q[p][i] != HOLD_MAX) hold_q[p][i] = hold_q[p][i] + 16'd1;
          end else begin
            if (ob[i]) rel_q[p][i] = hold_q[p][i];
            hold_q[p][i] = '0;
          end
          nc[i] = (w.button_word & BTN_MASK[i]) != 16'h0;
        end else begin
          if (oc[i]) rel_q[p][i] = hold_q[p][i];
          hold_q[p][i] = '0;
        end
      end
      prev_q[p] = oc;
      cur_q[p]  = nc;
      link_q[p] = w.linked;
      ltrig_q[p] = w.linked ? w.left_trig_in  : 8'h0;
      rtrig_q[p] = w.linked ? w.right_trig_in : 8'h0;
      lx_q[p] = w.linked ? w.left_x_in  : 16'h0;
      ly_q[p] = w.linked ? w.left_y_in  : 16'h0;
      rx_q[p] = w.linked ? w.right_x_in : 16'h0;
      ry_q[p] = w.linked ? w.right_y_in : 16'h0;
    end
    n = 0;
    for (int i = 0; i < PADS; i++) if (link_q[i]) n++;
    r.held           = cur_q[p][b];
    r.just_pressed   = cur_q[p][b] & ~prev_q[p][b];
    r.just_released  = prev_q[p][b] & ~cur_q[p][b];
    r.hold_count     = hold_q[p][b];
    r.release_hold   = rel_q[p][b];
    r.left_x_out     = lx_q[p];
    r.left_y_out     = ly_q[p];
    r.right_x_out    = rx_q[p];
    r.right_y_out    = ry_q[p];
    r.left_trig_out  = ltrig_q[p];
    r.right_trig_out = rtrig_q[p];
    r.linked_count   = n[2:0];
    return r;
  endfunction

  function automatic item_t word_of(logic op, logic [1:0] pad, logic linked,
                                    logic [15:0] btn, logic [7:0] lt, logic [7:0] rt,
                                    logic [15:0] lx, logic [15:0] ly,
                                    logic [15:0] rx, logic [15:0] ry, logic [3:0] sel);
    item_t w;
    w.op = op;
    w.pad = pad;
    w.linked = linked;
    w.button_word = btn;
    w.left_trig_in = lt;
    w.right_trig_in = rt;
    w.left_x_in = lx;
    w.left_y_in = ly;
    w.right_x_in = rx;
    w.right_y_in = ry;
    w.button_sel = sel;
    return w;
  endfunction

  function automatic result_t answer_of(logic h, logic jp, logic jr, logic [15:0] hc,
                                        logic [15:0] rh, logic [15:0] lx, logic [15:0] ly,
                                        logic [15:0] rx, logic [15:0] ry, logic [7:0] lt,
                                        logic [7:0] rt, logic [2:0] cnt);
    result_t r;
    r.held = h;
    r.just_pressed = jp;
    r.just_released = jr;
    r.hold_count = hc;
    r.release_hold = rh;
    r.left_x_out = lx;
    r.left_y_out = ly;
    r.right_x_out = rx;
    r.right_y_out = ry;
    r.left_trig_out = lt;
    r.right_trig_out = rt;
    r.linked_count = cnt;
    return r;
  endfunction

  function automatic item_t random_word(logic op, logic [1:0] pad, logic linked,
                                        logic [15:0] btn);
    return word_of(op, pad, linked, btn, 8'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom),
                   4'($urandom_range(0, 15)));
  endfunction

  task automatic cmp_field(string name, logic [15:0] e, logic [15:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      err_count++;
    end
  endtask

  task automatic send_word(item_t w, bit typed, result_t ans);
    item_word  <= w;
    pin_typed  <= typed;
    pin_answer <= ans;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // accepted words in, answers out
  always @(posedge clk) begin
    result_t pred;
    result_t e;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst) begin
      if (item_valid && item_ready) begin
        pred = track_pad_word(item_word);
        expected_answers.push_back(pin_typed ? pin_answer : pred);
      end
      if (result_valid && result_ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: answer with no word pending, actual %h", $time, result_word);
          err_count++;
        end else begin
          e = expected_answers.pop_front();
          cmp_field("held", 16'(e.held), 16'(result_word.held));
          cmp_field("just_pressed", 16'(e.just_pressed), 16'(result_word.just_pressed));
          cmp_field("just_released", 16'(e.just_released), 16'(result_word.just_released));
          cmp_field("hold_count", e.hold_count, result_word.hold_count);
          cmp_field("release_hold", e.release_hold, result_word.release_hold);
          cmp_field("left_x_out", e.left_x_out, result_word.left_x_out);
          cmp_field("left_y_out", e.left_y_out, result_word.left_y_out);
          cmp_field("right_x_out", e.right_x_out, result_word.right_x_out);
          cmp_field("right_y_out", e.right_y_out, result_word.right_y_out);
          cmp_field("left_trig_out", 16'(e.left_trig_out), 16'(result_word.left_trig_out));
          cmp_field("right_trig_out", 16'(e.right_trig_out),
                    16'(result_word.right_trig_out));
          cmp_field("linked_count", 16'(e.linked_count), 16'(result_word.linked_count));
          n_checked++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int k;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      result_ready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                          : $urandom_range(1, 8)) @(posedge clk);
      k = $urandom_range(0, 3);
      if (k > 0) begin
        result_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
    end
  end

  initial begin
    dir_row_t    tab[$];
    dir_row_t    row;
    result_t     none;
    logic [15:0] last_btn [PADS];
    logic [15:0] btn;
    logic [1:0]  pd;
    int          r;

    for (int i = 0; i < PADS; i++) begin
      cur_q[i] = '0;
      prev_q[i] = '0;
      link_q[i] = 1'b0;
      ltrig_q[i] = '0;
      rtrig_q[i] = '0;
      lx_q[i] = '0;
      ly_q[i] = '0;
      rx_q[i] = '0;
      ry_q[i] = '0;
      last_btn[i] = '0;
      for (int j = 0; j < BUTTONS; j++) begin
        hold_q[i][j] = '0;
        rel_q[i][j] = '0;
      end
    end
    none = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // typed rows: reset state, query leaves state alone, extremes on first press
    row.typed = 1'b1;
    row.w = word_of(OP_QUERY, 2'd0, 1'b0, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 4'd0);
    row.ans = none;
    tab.push_back(row);
    row.w = word_of(OP_QUERY, 2'd3, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000,
                    16'h7FFF, 16'h8000, 4'd15);
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd0, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000,
                    16'h8000, 16'h7FFF, 4'd0);
    row.ans = answer_of(1'b1, 1'b1, 1'b0, 16'h0, 16'h0, 16'h7FFF, 16'h8000, 16'h8000,
                        16'h7FFF, 8'hFF, 8'hFF, 3'd1);
    tab.push_back(row);

    row.typed = 1'b0;
    row.ans = none;
    row.w = word_of(OP_POLL, 2'd0, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000,
                    16'h8000, 16'h7FFF, 4'd0);
    tab.push_back(row);
    row.w.button_sel = 4'd13;
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd0, 1'b1, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 4'd0);
    tab.push_back(row);
    tab.push_back(row);
    // unmasked bits only
    row.w = word_of(OP_POLL, 2'd1, 1'b1, 16'h0C00, 8'h01, 8'h80, 16'hFFFF, 16'h0001,
                    16'h8001, 16'h7FFE, 4'd4);
    tab.push_back(row);
    // selector beyond the last button
    row.w = word_of(OP_POLL, 2'd2, 1'b1, 16'h0008, 8'h55, 8'hAA, 16'h1234, 16'hEDCB,
                    16'h0F0F, 16'hF0F0, 4'd14);
    tab.push_back(row);
    row.w = word_of(OP_QUERY, 2'd2, 1'b0, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 4'd15);
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd2, 1'b1, 16'h0008, 8'h55, 8'hAA, 16'h1234, 16'hEDCB,
                    16'h0F0F, 16'hF0F0, 4'd13);
    tab.push_back(row);
    // disconnect while held, junk on the inputs
    row.w = word_of(OP_POLL, 2'd2, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF,
                    16'h8000, 16'h8000, 4'd13);
    tab.push_back(row);
    row.w = word_of(OP_QUERY, 2'd2, 1'b0, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 4'd13);
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd3, 1'b1, 16'hC000, 8'h10, 8'h20, 16'h0100, 16'h0200,
                    16'h0300, 16'h0400, 4'd3);
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd3, 1'b1, 16'h5555, 8'h11, 8'h22, 16'h8000, 16'h8000,
                    16'h8000, 16'h8000, 4'd2);
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd3, 1'b1, 16'hAAAA, 8'h00, 8'hFF, 16'h7FFF, 16'h7FFF,
                    16'h7FFF, 16'h7FFF, 4'd2);
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd0, 1'b0, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 16'h0,
                    16'h0, 4'd0);
    tab.push_back(row);
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd2, 1'b1, 16'hFFFF, 8'h7F, 8'h7F, 16'h0001, 16'h0002,
                    16'h0003, 16'h0004, 4'd9);
    tab.push_back(row);
    row.w = word_of(OP_QUERY, 2'd1, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 4'd0);
    tab.push_back(row);
    row.w = word_of(OP_POLL, 2'd0, 1'b1, 16'hFFFF, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0,
                    16'h0, 4'd10);
    tab.push_back(row);

    foreach (tab[i]) send_word(tab[i].w, tab[i].typed, tab[i].ans);

    // hold A on pad 1 for a run of polls, then release and capture
    for (int i = 0; i < N_HOLD; i++)
      send_word(random_word(OP_POLL, 2'd1, 1'b1, 16'h1000), 1'b0, none);
    row.w = random_word(OP_POLL, 2'd1, 1'b1, 16'h0000);
    row.w.button_sel = 4'd0;
    send_word(row.w, 1'b0, none);
    send_word(row.w, 1'b0, none);

    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      pd = 2'($urandom_range(0, 3));
      if (r < 20) begin
        send_word(random_word(OP_QUERY, pd, 1'($urandom), 16'($urandom)), 1'b0, none);
      end else if (r < 30) begin
        send_word(random_word(OP_POLL, pd, 1'b0, 16'($urandom)), 1'b0, none);
        last_btn[pd] = '0;
      end else begin
        if (r < 38) begin
          btn = 16'($urandom);
        end else begin
          btn = last_btn[pd];
          if ($urandom_range(0, 9) < 4) btn ^= BTN_MASK[$urandom_range(0, 13)];
          if ($urandom_range(0, 9) < 1) btn ^= BTN_MASK[$urandom_range(0, 13)];
        end
        last_btn[pd] = btn;
        send_word(random_word(OP_POLL, pd, 1'b1, btn), 1'b0, none);
      end
    end

    if (item_valid) item_valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d answers for %0d words: directed table, hold and release run",
             n_checked, n_sent);
    $display("and %0d random polls and queries with bursty input and receiver stalls",
             N_RANDOM);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/gbh_pkg.sv
design/gbh_pad_ram.sv
design/gbh_row_update.sv
design/gamepad_button_hold_tracker.sv
dv/tb_gamepad_button_hold_tracker.sv
